// ===== rtl/plc_pkg.sv =====
// Shared constants and register codes for the piecewise linear calibration core.
package plc_pkg;

  // Calibration points and segments between them.
  localparam int unsigned NUM_POINTS = 5;
  localparam int unsigned NUM_SEGS   = NUM_POINTS - 1;
  localparam int unsigned POINT_W    = 3;

  // Fixed field widths.
  localparam int unsigned BASE_W = 12;
  localparam int unsigned STEP_W = 10;
  localparam int unsigned OUT_W  = 13;
  localparam int unsigned QUOT_W = STEP_W;
  localparam int unsigned IDX_W  = 3;

  // Reset values of the breakpoints and the default step in whole degrees.
  localparam int unsigned BpReset [NUM_POINTS] = '{180, 1000, 2100, 3000, 3900};
  localparam int unsigned StepResetDeg = 45;

  // Configuration register indexes.
  typedef enum logic [IDX_W-1:0] {
    REG_BP0        = 3'd0,
    REG_BP1        = 3'd1,
    REG_BP2        = 3'd2,
    REG_BP3        = 3'd3,
    REG_BP4        = 3'd4,
    REG_ANGLE_BASE = 3'd5,
    REG_ANGLE_STEP = 3'd6
  } reg_idx_e;

endpackage

// ===== rtl/plc_seg_select.sv =====
// First pipeline stage: picks the segment, its offset, width and starting angle.
module plc_seg_select #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic [SAMPLE_BITS-1:0]      sample_i,
  input  logic [SAMPLE_BITS-1:0]      bp_i [plc_pkg::NUM_POINTS],
  input  logic [plc_pkg::BASE_W-1:0]  angle_base_i,
  input  logic [plc_pkg::STEP_W-1:0]  angle_step_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic [SAMPLE_BITS-1:0]      dist_o,
  output logic [SAMPLE_BITS-1:0]      width_o,
  output logic [plc_pkg::OUT_W-1:0]   angle_o
);

  logic                          valid_q;
  logic [SAMPLE_BITS-1:0]        dist_d, dist_q;
  logic [SAMPLE_BITS-1:0]        width_d, width_q;
  logic [plc_pkg::OUT_W-1:0]     angle_d, angle_q;
  logic [plc_pkg::POINT_W-1:0]   idx;
  logic [SAMPLE_BITS-1:0]        lo_bp, hi_bp;
  logic                          found;

  // Segment search: clamp below and above, else the first enclosing segment.
  always_comb begin
    idx   = plc_pkg::POINT_W'(plc_pkg::NUM_POINTS - 1);
    lo_bp = bp_i[0];
    hi_bp = bp_i[1];
    found = 1'b0;
    if (sample_i <= bp_i[0]) begin
      idx = '0;
    end else if (sample_i >= bp_i[plc_pkg::NUM_POINTS-1]) begin
      idx = plc_pkg::POINT_W'(plc_pkg::NUM_POINTS - 1);
    end else begin
      for (int i = 0; i < plc_pkg::NUM_SEGS; i++) begin
        if (!found && sample_i >= bp_i[i] && sample_i <= bp_i[i+1]) begin
          found = 1'b1;
          idx   = plc_pkg::POINT_W'(i);
          lo_bp = bp_i[i];
          hi_bp = bp_i[i+1];
        end
      end
    end
    // Without a segment of non-zero width the quotient is forced to zero.
    if (found && hi_bp != lo_bp) begin
      dist_d  = sample_i - lo_bp;
      width_d = hi_bp - lo_bp;
    end else begin
      dist_d  = '0;
      width_d = SAMPLE_BITS'(1);
    end
    angle_d = plc_pkg::OUT_W'(angle_base_i)
            + plc_pkg::OUT_W'(idx) * plc_pkg::OUT_W'(angle_step_i);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      dist_q  <= dist_d;
      width_q <= width_d;
      angle_q <= angle_d;
    end
  end

  assign valid_o = valid_q;
  assign dist_o  = dist_q;
  assign width_o = width_q;
  assign angle_o = angle_q;

endmodule

// ===== rtl/plc_div_cell.sv =====
// One cell of the division chain: settles a single quotient bit per word.
module plc_div_cell #(
  parameter int unsigned SAMPLE_BITS = 12,
  parameter int unsigned QBIT        = 0
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    valid_i,
  output logic                                    ready_o,
  input  logic [SAMPLE_BITS+plc_pkg::STEP_W-1:0]  rem_i,
  input  logic [SAMPLE_BITS-1:0]                  div_i,
  input  logic [plc_pkg::QUOT_W-1:0]              quot_i,
  input  logic [plc_pkg::OUT_W-1:0]               angle_i,
  output logic                                    valid_o,
  input  logic                                    ready_i,
  output logic [SAMPLE_BITS+plc_pkg::STEP_W-1:0]  rem_o,
  output logic [SAMPLE_BITS-1:0]                  div_o,
  output logic [plc_pkg::QUOT_W-1:0]              quot_o,
  output logic [plc_pkg::OUT_W-1:0]               angle_o
);

  localparam int unsigned RemW = SAMPLE_BITS + plc_pkg::STEP_W;

  logic                        valid_q;
  logic [RemW-1:0]             rem_d, rem_q;
  logic [SAMPLE_BITS-1:0]      div_q;
  logic [plc_pkg::QUOT_W-1:0]  quot_d, quot_q;
  logic [plc_pkg::OUT_W-1:0]   angle_q;
  logic [RemW-1:0]             shifted_div;

  // Restoring step: subtract the divisor at this bit weight if it fits.
  always_comb begin
    shifted_div = RemW'(div_i) << QBIT;
    if (rem_i >= shifted_div) begin
      rem_d  = rem_i - shifted_div;
      quot_d = quot_i | (plc_pkg::QUOT_W'(1) << QBIT);
    end else begin
      rem_d  = rem_i;
      quot_d = quot_i;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rem_q   <= rem_d;
      div_q   <= div_i;
      quot_q  <= quot_d;
      angle_q <= angle_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign div_o   = div_q;
  assign quot_o  = quot_q;
  assign angle_o = angle_q;

endmodule

// ===== rtl/piecewise_linear_calibration_core.sv =====
// Piecewise linear calibration core: maps a converter sample onto an angle in sixteenths of
// a degree by interpolating between five programmable breakpoints. A word is taken on every
// cycle that in_stall_o is low and passes through the segment select register, the multiply
// register for the offset-times-step multiply, the ten division cells (one quotient bit
// each) and the output register, in order. Every stage holds its word only while
// the stage after it is full and stalled, so bubbles close up and throughput stays at one
// word per cycle whenever the output is not stalled. Samples at or below the first breakpoint
// give the first angle, samples at or above the last give the last angle, a zero-width
// segment gives its lower angle and unordered breakpoints with no enclosing segment give the
// last angle. Configuration is always ready and should only be written while the core is
// empty.
module piecewise_linear_calibration_core #(
  parameter int unsigned SAMPLE_BITS = 12,
  parameter int unsigned FRAC_BITS   = 4,
  localparam int unsigned CfgW = (SAMPLE_BITS > plc_pkg::BASE_W) ? SAMPLE_BITS
                                                                 : plc_pkg::BASE_W
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Sample input
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [SAMPLE_BITS-1:0]      raw_sample_i,
  // Angle output
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [plc_pkg::OUT_W-1:0]   angle_q4_o,
  // Configuration writes
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [plc_pkg::IDX_W-1:0]   cfg_index_i,
  input  logic [CfgW-1:0]             cfg_wdata_i
);

  localparam int unsigned RemW  = SAMPLE_BITS + plc_pkg::STEP_W;
  localparam int unsigned Cells = plc_pkg::QUOT_W;

  // Configuration registers.
  logic [SAMPLE_BITS-1:0]       bp_q [plc_pkg::NUM_POINTS];
  logic [plc_pkg::BASE_W-1:0]   angle_base_q;
  logic [plc_pkg::STEP_W-1:0]   angle_step_q;

  // Segment select stage outputs.
  logic                         sel_ready, sel_valid;
  logic [SAMPLE_BITS-1:0]       sel_dist, sel_width;
  logic [plc_pkg::OUT_W-1:0]    sel_angle;

  // Multiply stage.
  logic                         mul_ready, mul_valid_q;
  logic [RemW-1:0]              prod_q;
  logic [SAMPLE_BITS-1:0]       mul_div_q;
  logic [plc_pkg::OUT_W-1:0]    mul_angle_q;

  // Links between the division cells; link k feeds cell k.
  logic                         lnk_valid [Cells+1];
  logic                         lnk_ready [Cells+1];
  logic [RemW-1:0]              lnk_rem   [Cells+1];
  logic [SAMPLE_BITS-1:0]       lnk_div   [Cells+1];
  logic [plc_pkg::QUOT_W-1:0]   lnk_quot  [Cells+1];
  logic [plc_pkg::OUT_W-1:0]    lnk_angle [Cells+1];

  // Output register.
  logic                         out_ready;
  logic                         out_valid_q;
  logic [plc_pkg::OUT_W-1:0]    angle_q;

  // Register writes; an index past the list is ignored.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < plc_pkg::NUM_POINTS; i++) begin
        bp_q[i] <= SAMPLE_BITS'(plc_pkg::BpReset[i]);
      end
      angle_base_q <= '0;
      angle_step_q <= plc_pkg::STEP_W'(plc_pkg::StepResetDeg << FRAC_BITS);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (plc_pkg::reg_idx_e'(cfg_index_i))
        plc_pkg::REG_BP0:        bp_q[0] <= cfg_wdata_i[SAMPLE_BITS-1:0];
        plc_pkg::REG_BP1:        bp_q[1] <= cfg_wdata_i[SAMPLE_BITS-1:0];
        plc_pkg::REG_BP2:        bp_q[2] <= cfg_wdata_i[SAMPLE_BITS-1:0];
        plc_pkg::REG_BP3:        bp_q[3] <= cfg_wdata_i[SAMPLE_BITS-1:0];
        plc_pkg::REG_BP4:        bp_q[4] <= cfg_wdata_i[SAMPLE_BITS-1:0];
        plc_pkg::REG_ANGLE_BASE: angle_base_q <= cfg_wdata_i[plc_pkg::BASE_W-1:0];
        plc_pkg::REG_ANGLE_STEP: angle_step_q <= cfg_wdata_i[plc_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Segment selection.
  plc_seg_select #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_seg_select (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (in_valid_i),
    .ready_o      (sel_ready),
    .sample_i     (raw_sample_i),
    .bp_i         (bp_q),
    .angle_base_i (angle_base_q),
    .angle_step_i (angle_step_q),
    .valid_o      (sel_valid),
    .ready_i      (mul_ready),
    .dist_o       (sel_dist),
    .width_o      (sel_width),
    .angle_o      (sel_angle)
  );

  assign in_stall_o = !sel_ready;

  // Offset times step; the quotient of this by the width never exceeds the step.
  assign mul_ready = !mul_valid_q || lnk_ready[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
    end else if (mul_ready) begin
      mul_valid_q <= sel_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_ready && sel_valid) begin
      prod_q      <= RemW'(sel_dist) * RemW'(angle_step_q);
      mul_div_q   <= sel_width;
      mul_angle_q <= sel_angle;
    end
  end

  assign lnk_valid[0] = mul_valid_q;
  assign lnk_rem[0]   = prod_q;
  assign lnk_div[0]   = mul_div_q;
  assign lnk_quot[0]  = '0;
  assign lnk_angle[0] = mul_angle_q;

  // Division chain, most significant quotient bit first.
  for (genvar k = 0; k < Cells; k++) begin : g_cell
    plc_div_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .QBIT        (Cells - 1 - k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (lnk_valid[k]),
      .ready_o (lnk_ready[k]),
      .rem_i   (lnk_rem[k]),
      .div_i   (lnk_div[k]),
      .quot_i  (lnk_quot[k]),
      .angle_i (lnk_angle[k]),
      .valid_o (lnk_valid[k+1]),
      .ready_i (lnk_ready[k+1]),
      .rem_o   (lnk_rem[k+1]),
      .div_o   (lnk_div[k+1]),
      .quot_o  (lnk_quot[k+1]),
      .angle_o (lnk_angle[k+1])
    );
  end

  assign lnk_ready[Cells] = out_ready;

  // Output register: segment start angle plus the truncated quotient.
  assign out_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= lnk_valid[Cells];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && lnk_valid[Cells]) begin
      angle_q <= lnk_angle[Cells] + plc_pkg::OUT_W'(lnk_quot[Cells]);
    end
  end

  assign out_valid_o = out_valid_q;
  assign angle_q4_o  = angle_q;

endmodule
